FILE: rtl/gcsp_pkg.sv
// ----------------------------------------------------------------------------
// gcsp_pkg
// Shared types and codes of the command stream parser: parse phases, record
// kinds and the record that travels from the decoder to the result queue.
// ----------------------------------------------------------------------------
package gcsp_pkg;

   localparam int QUEUE_DEPTH = 4;

   // record kinds
   localparam logic [3:0] KIND_NOP        = 4'd0;
   localparam logic [3:0] KIND_CP_WRITE   = 4'd1;
   localparam logic [3:0] KIND_XF_WORD    = 4'd2;
   localparam logic [3:0] KIND_XF_INDEXED = 4'd3;
   localparam logic [3:0] KIND_CALL_LIST  = 4'd4;
   localparam logic [3:0] KIND_INVALIDATE = 4'd5;
   localparam logic [3:0] KIND_BP_WRITE   = 4'd6;
   localparam logic [3:0] KIND_DRAW       = 4'd7;
   localparam logic [3:0] KIND_VERTEX     = 4'd8;
   localparam logic [3:0] KIND_UNKNOWN    = 4'd9;

   // opcodes (command byte bits 7:3)
   localparam logic [4:0] OP_NOP     = 5'h00;
   localparam logic [4:0] OP_CP      = 5'h01;
   localparam logic [4:0] OP_XF      = 5'h02;
   localparam logic [4:0] OP_IDX_A   = 5'h04;
   localparam logic [4:0] OP_IDX_B   = 5'h05;
   localparam logic [4:0] OP_IDX_C   = 5'h06;
   localparam logic [4:0] OP_IDX_D   = 5'h07;
   localparam logic [4:0] OP_CALL    = 5'h08;
   localparam logic [4:0] OP_INVAL   = 5'h09;
   localparam logic [4:0] OP_BP      = 5'h0C;
   localparam logic [4:0] OP_DRAW_0  = 5'h10;
   localparam logic [4:0] OP_DRAW_2  = 5'h12;
   localparam logic [4:0] OP_DRAW_3  = 5'h13;
   localparam logic [4:0] OP_DRAW_4  = 5'h14;
   localparam logic [4:0] OP_DRAW_5  = 5'h15;
   localparam logic [4:0] OP_DRAW_6  = 5'h16;
   localparam logic [4:0] OP_DRAW_7  = 5'h17;

   // configuration register indexes
   localparam logic CSR_VERTEX_SIZE   = 1'b0;
   localparam logic CSR_RAM_ADDR_MASK = 1'b1;

   localparam logic [31:0] RAM_ADDR_MASK_RESET = 32'h01FF_FFFF;

   typedef enum logic [3:0] {
      PH_IDLE, PH_CP_ADDR, PH_CP_DATA, PH_XF_HDR, PH_XF_WORD,
      PH_IDX_INDEX, PH_IDX_DATA, PH_CALL_ADDR, PH_CALL_SIZE,
      PH_BP_DATA, PH_DRAW_COUNT, PH_VERTEX
   } phase_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] reg_addr;
      logic [31:0] data;
      logic [31:0] count;
      logic [15:0] index;
      logic [3:0]  variant;
      logic [2:0]  vat;
      logic        last;
   } record_type;

endpackage

FILE: rtl/gcsp_front.sv
// ----------------------------------------------------------------------------
// gcsp_front
// Byte decoder: classifies command bytes, assembles big-endian words and
// builds one record per completed command, word or vertex byte.
// ----------------------------------------------------------------------------
module gcsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          in_byte,
   input  logic [7:0]          vertex_size,
   input  logic [31:0]         ram_addr_mask,
   output logic                rec_valid,
   output gcsp_pkg::record_type rec
);
   import gcsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [2:0]  bcnt_ff, bcnt_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] hdr_ff, hdr_in;
   logic [16:0] wleft_ff, wleft_in;
   logic [23:0] vleft_ff, vleft_in;

   logic [31:0] word;
   logic [2:0]  bcnt_next;
   logic [2:0]  needed;
   logic        done;
   logic [16:0] xf_len;
   logic [23:0] total;
   logic [4:0]  op;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cmd_ff   <= '0;
         bcnt_ff  <= '0;
         asm_ff   <= '0;
         hdr_ff   <= '0;
         wleft_ff <= '0;
         vleft_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         bcnt_ff  <= bcnt_in;
         asm_ff   <= asm_in;
         hdr_ff   <= hdr_in;
         wleft_ff <= wleft_in;
         vleft_ff <= vleft_in;
      end
   end

   // assemble words and decode the current byte
   always_comb begin
      word      = {asm_ff[23:0], in_byte};
      bcnt_next = bcnt_ff + 3'd1;
      unique case (phase_ff)
         PH_CP_ADDR:                           needed = 3'd1;
         PH_IDX_INDEX, PH_IDX_DATA, PH_DRAW_COUNT: needed = 3'd2;
         default:                              needed = 3'd4;
      endcase
      done   = (bcnt_next >= needed);
      xf_len = {1'b0, hdr_ff[31:16]} + 17'd1;
      // 16 x 8 product always fits in 24 bits
      total  = {8'd0, word[15:0]} * {16'd0, vertex_size};
      op     = in_byte[7:3];

      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      bcnt_in   = bcnt_ff;
      asm_in    = asm_ff;
      hdr_in    = hdr_ff;
      wleft_in  = wleft_ff;
      vleft_in  = vleft_ff;
      rec_valid = 1'b0;
      rec       = '0;
      rec.vat   = cmd_ff[2:0];

      unique case (phase_ff)
         // emit one record per vertex byte
         PH_VERTEX: begin
            rec_valid    = 1'b1;
            rec.kind     = KIND_VERTEX;
            rec.data     = {24'd0, in_byte};
            rec.count    = hdr_ff;
            rec.variant  = cmd_ff[6:3];
            rec.last     = (vleft_ff <= 24'd1);
            if (vleft_ff <= 24'd1) begin
               vleft_in = '0;
               phase_in = PH_IDLE;
            end else begin
               vleft_in = vleft_ff - 24'd1;
            end
         end
         // classify a command byte
         PH_IDLE: begin
            cmd_in   = in_byte;
            bcnt_in  = '0;
            asm_in   = '0;
            rec.vat  = in_byte[2:0];
            rec.last = 1'b1;
            unique case (op)
               OP_NOP: begin
                  rec_valid = 1'b1;
                  rec.kind  = KIND_NOP;
               end
               OP_CP:   phase_in = PH_CP_ADDR;
               OP_XF:   phase_in = PH_XF_HDR;
               OP_IDX_A, OP_IDX_B, OP_IDX_C, OP_IDX_D: phase_in = PH_IDX_INDEX;
               OP_CALL: phase_in = PH_CALL_ADDR;
               OP_INVAL: begin
                  rec_valid = 1'b1;
                  rec.kind  = KIND_INVALIDATE;
               end
               OP_BP:   phase_in = PH_BP_DATA;
               OP_DRAW_0, OP_DRAW_2, OP_DRAW_3, OP_DRAW_4, OP_DRAW_5, OP_DRAW_6,
               OP_DRAW_7: phase_in = PH_DRAW_COUNT;
               default: begin
                  rec_valid = 1'b1;
                  rec.kind  = KIND_UNKNOWN;
               end
            endcase
         end
         // collect operand bytes
         default: begin
            if (!done) begin
               asm_in  = word;
               bcnt_in = bcnt_next;
            end else begin
               asm_in  = '0;
               bcnt_in = '0;
               unique case (phase_ff)
                  PH_CP_ADDR: begin
                     hdr_in   = {24'd0, word[7:0]};
                     phase_in = PH_CP_DATA;
                  end
                  PH_CP_DATA: begin
                     phase_in     = PH_IDLE;
                     rec_valid    = 1'b1;
                     rec.kind     = KIND_CP_WRITE;
                     rec.reg_addr = hdr_ff[15:0];
                     rec.data     = word;
                     rec.last     = 1'b1;
                  end
                  PH_XF_HDR: begin
                     hdr_in   = word;
                     wleft_in = {1'b0, word[31:16]} + 17'd1;
                     phase_in = PH_XF_WORD;
                  end
                  PH_XF_WORD: begin
                     rec_valid    = 1'b1;
                     rec.kind     = KIND_XF_WORD;
                     rec.reg_addr = hdr_ff[15:0];
                     rec.data     = word;
                     rec.count    = {15'd0, xf_len};
                     rec.index    = 16'(xf_len - wleft_ff);
                     rec.last     = (wleft_ff <= 17'd1);
                     if (wleft_ff <= 17'd1) begin
                        wleft_in = '0;
                        phase_in = PH_IDLE;
                     end else begin
                        wleft_in = wleft_ff - 17'd1;
                     end
                  end
                  PH_IDX_INDEX: begin
                     hdr_in   = {16'd0, word[15:0]};
                     phase_in = PH_IDX_DATA;
                  end
                  PH_IDX_DATA: begin
                     phase_in     = PH_IDLE;
                     rec_valid    = 1'b1;
                     rec.kind     = KIND_XF_INDEXED;
                     rec.reg_addr = {4'd0, word[11:0]};
                     rec.count    = {27'd0, {1'b0, word[15:12]} + 5'd1};
                     rec.index    = hdr_ff[15:0];
                     rec.variant  = cmd_ff[6:3] - 4'd4;
                     rec.last     = 1'b1;
                  end
                  PH_CALL_ADDR: begin
                     hdr_in   = word & ram_addr_mask;
                     phase_in = PH_CALL_SIZE;
                  end
                  PH_CALL_SIZE: begin
                     phase_in  = PH_IDLE;
                     rec_valid = 1'b1;
                     rec.kind  = KIND_CALL_LIST;
                     rec.data  = hdr_ff;
                     rec.count = word;
                     rec.last  = 1'b1;
                  end
                  PH_BP_DATA: begin
                     phase_in     = PH_IDLE;
                     rec_valid    = 1'b1;
                     rec.kind     = KIND_BP_WRITE;
                     rec.reg_addr = {8'd0, word[31:24]};
                     rec.data     = {8'd0, word[23:0]};
                     rec.last     = 1'b1;
                  end
                  default: begin
                     hdr_in      = {16'd0, word[15:0]};
                     rec_valid   = 1'b1;
                     rec.kind    = KIND_DRAW;
                     rec.count   = {16'd0, word[15:0]};
                     rec.variant = cmd_ff[6:3];
                     rec.last    = (total == 24'd0);
                     if (total != 24'd0) begin
                        vleft_in = total;
                        phase_in = PH_VERTEX;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               endcase
            end
         end
      endcase
   end

endmodule

FILE: rtl/gcsp_queue.sv
// ----------------------------------------------------------------------------
// gcsp_queue
// Result queue: holds decoded records until the consumer pops them, so the
// decoder keeps taking bytes while results wait, until the queue is full.
// ----------------------------------------------------------------------------
module gcsp_queue #(
   parameter int Depth = gcsp_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gcsp_pkg::record_type push_rec,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output gcsp_pkg::record_type head
);
   import gcsp_pkg::*;

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   record_type      slot_ff [Depth];
   logic [AW-1:0]   wptr_ff, wptr_in;
   logic [AW-1:0]   rptr_ff, rptr_in;
   logic [AW:0]     fill_ff, fill_in;
   logic            do_push, do_pop;

   assign full    = (fill_ff == (AW+1)'(Depth));
   assign empty   = (fill_ff == '0);
   assign head    = slot_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // advance pointers and fill level
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == AW'(Depth - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == AW'(Depth - 1)) ? '0 : rptr_ff + 1'b1;
      end
      fill_in = fill_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   // store records
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_rec;
      end
   end

endmodule

FILE: rtl/graphics_command_stream_parser_core.sv
// ----------------------------------------------------------------------------
// graphics_command_stream_parser_core
// Timing: a record is visible in the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle while the queue is not full; the decoder and the
// record queue (depth QueueDepth) let the byte side run while results wait to be popped.
// Reset: synchronous; parser returns to awaiting an opcode, queue empties,
// vertex_size clears and ram_addr_mask returns to 0x01FFFFFF.
// ----------------------------------------------------------------------------
module graphics_command_stream_parser_core #(
   parameter int QueueDepth = gcsp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_kind,
   output logic [15:0] rsp_reg_addr,
   output logic [31:0] rsp_data,
   output logic [31:0] rsp_count,
   output logic [15:0] rsp_index,
   output logic [3:0]  rsp_variant,
   output logic [2:0]  rsp_vat,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata
);
   import gcsp_pkg::*;

   logic [7:0]  vsize_ff;
   logic [31:0] mask_ff;
   logic        take;
   logic        rec_valid;
   record_type  rec;
   record_type  head;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vsize_ff <= '0;
         mask_ff  <= RAM_ADDR_MASK_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_VERTEX_SIZE:   vsize_ff <= csr_wdata[7:0];
            CSR_RAM_ADDR_MASK: mask_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign take = req_push && !req_full;

   gcsp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .in_byte       (req_in_byte),
      .vertex_size   (vsize_ff),
      .ram_addr_mask (mask_ff),
      .rec_valid     (rec_valid),
      .rec           (rec)
   );

   gcsp_queue #(.Depth(QueueDepth)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (take && rec_valid),
      .push_rec (rec),
      .pop      (rsp_pop),
      .full     (req_full),
      .empty    (rsp_empty),
      .head     (head)
   );

   assign rsp_kind     = head.kind;
   assign rsp_reg_addr = head.reg_addr;
   assign rsp_data     = head.data;
   assign rsp_count    = head.count;
   assign rsp_index    = head.index;
   assign rsp_variant  = head.variant;
   assign rsp_vat      = head.vat;
   assign rsp_last     = head.last;

endmodule
